// File: rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int FIELD_W = 13;
    localparam int HDR_W   = 2 * FIELD_W + 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_FIT = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PREP,
        S_WALK,
        S_CHK,
        S_FIT,
        S_SPLIT1,
        S_SPLIT2,
        S_NEXT,
        S_NEXT2,
        S_MRG,
        S_MRG2,
        S_FREE_CHK,
        S_FREE_RD
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] cap;
        logic               res;
    } t_header;

endpackage

// File: rtl/ffha_ram.sv
module ffha_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ffha_alu.sv
module ffha_alu #(
    parameter int WIDTH = 18
) (
    input  ffha_pkg::t_alu_op i_op,
    input  logic [WIDTH-1:0]  i_a,
    input  logic [WIDTH-1:0]  i_b,
    output logic [WIDTH-1:0]  o_sum,
    output logic              o_borrow
);

    logic [WIDTH:0] full;

    always_comb begin
        unique case (i_op)
            ffha_pkg::ALU_ADD: full = {1'b0, i_a} + {1'b0, i_b};
            ffha_pkg::ALU_SUB: full = {1'b0, i_a} - {1'b0, i_b};
            default:           full = '0;
        endcase
    end

    assign o_sum    = full[WIDTH-1:0];
    assign o_borrow = (i_op == ffha_pkg::ALU_SUB) && full[WIDTH];

endmodule

// File: rtl/first_fit_heap_allocator_unit.sv
// Free item: the block checks the offset, then rewrites the header as free, or answers
// after the check alone when the offset is below the header size. Allocate item: the walk
// steps past reserved blocks and too-small free blocks, merges free neighbours, and grants
// with one header write (two with a split); the walk reads each block's header in turn.
// A new item is taken in the cycle the result is shown; the receiver cannot stall.
// Reset is synchronous: the block then writes the first header in its init state, busy high.
module first_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES   = 8192,
    parameter int HEADER_BYTES = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [12:0] i_request_size,
    input  logic [12:0] i_release_offset,
    output logic        o_done,
    output logic [12:0] o_payload_offset,
    output logic [12:0] o_granted_capacity,
    output logic        o_status
);

    localparam int FW = ffha_pkg::FIELD_W;
    localparam int AW = $clog2(HEAP_BYTES);
    localparam int WW = ((AW > FW) ? AW : FW) + 2;
    localparam logic [WW-1:0] HEAP_W   = WW'(HEAP_BYTES);
    localparam logic [WW-1:0] HDR_LEN  = WW'(HEADER_BYTES);
    localparam logic [FW-1:0] INIT_CAP = FW'(HEAP_BYTES - HEADER_BYTES);

    ffha_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_pos, n_pos;
    logic [FW-1:0] r_want, n_want;
    logic [FW-1:0] r_rel, n_rel;
    logic [WW-1:0] r_wh, n_wh;
    logic [WW-1:0] r_pay, n_pay;
    logic [FW-1:0] r_cap, n_cap;
    logic          r_res, n_res;
    logic [WW-1:0] r_next, n_next;
    logic [WW-1:0] r_acc, n_acc;
    logic          r_done, n_done;
    logic [FW-1:0] r_out_off, n_out_off;
    logic [FW-1:0] r_out_cap, n_out_cap;
    logic          r_out_status, n_out_status;

    ffha_pkg::t_alu_op alu_op;
    logic [WW-1:0]     alu_a, alu_b, alu_sum;
    logic              alu_borrow;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    ffha_pkg::t_header ram_wdata, ram_rdata;

    ffha_alu #(.WIDTH(WW)) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_sum    (alu_sum),
        .o_borrow (alu_borrow)
    );

    ffha_ram #(.WIDTH(ffha_pkg::HDR_W), .DEPTH(HEAP_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffha_pkg::S_INIT: n_state = ffha_pkg::S_IDLE;
            ffha_pkg::S_IDLE: begin
                if (start) begin
                    n_state = (i_command == ffha_pkg::CMD_FREE) ? ffha_pkg::S_FREE_CHK
                                                               : ffha_pkg::S_PREP;
                end
            end
            ffha_pkg::S_PREP: n_state = ffha_pkg::S_WALK;
            ffha_pkg::S_WALK: begin
                n_state = (alu_sum > HEAP_W) ? ffha_pkg::S_IDLE : ffha_pkg::S_CHK;
            end
            ffha_pkg::S_CHK: begin
                n_state = (!ram_rdata.res && !alu_borrow) ? ffha_pkg::S_FIT
                                                          : ffha_pkg::S_NEXT;
            end
            ffha_pkg::S_FIT: begin
                n_state = alu_borrow ? ffha_pkg::S_SPLIT1 : ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_SPLIT1: n_state = ffha_pkg::S_SPLIT2;
            ffha_pkg::S_SPLIT2: n_state = ffha_pkg::S_IDLE;
            ffha_pkg::S_NEXT:   n_state = ffha_pkg::S_NEXT2;
            ffha_pkg::S_NEXT2: begin
                priority if (alu_sum > HEAP_W) begin
                    n_state = ffha_pkg::S_IDLE;
                end else if (r_res) begin
                    n_state = ffha_pkg::S_WALK;
                end else begin
                    n_state = ffha_pkg::S_MRG;
                end
            end
            ffha_pkg::S_MRG: begin
                n_state = ram_rdata.res ? ffha_pkg::S_WALK : ffha_pkg::S_MRG2;
            end
            ffha_pkg::S_MRG2: n_state = ffha_pkg::S_WALK;
            ffha_pkg::S_FREE_CHK: begin
                n_state = (alu_borrow || alu_sum >= HEAP_W) ? ffha_pkg::S_IDLE
                                                            : ffha_pkg::S_FREE_RD;
            end
            ffha_pkg::S_FREE_RD: n_state = ffha_pkg::S_IDLE;
            default: n_state = ffha_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_pos        = r_pos;
        n_want       = r_want;
        n_rel        = r_rel;
        n_wh         = r_wh;
        n_pay        = r_pay;
        n_cap        = r_cap;
        n_res        = r_res;
        n_next       = r_next;
        n_acc        = r_acc;
        n_done       = 1'b0;
        n_out_off    = r_out_off;
        n_out_cap    = r_out_cap;
        n_out_status = r_out_status;
        alu_op       = ffha_pkg::ALU_ADD;
        alu_a        = '0;
        alu_b        = '0;
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = '{size: r_want, cap: r_cap, res: 1'b1};
        ram_raddr    = r_pos;
        unique case (r_state)
            ffha_pkg::S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{size: INIT_CAP, cap: INIT_CAP, res: 1'b0};
            end
            ffha_pkg::S_IDLE: begin
                if (start) begin
                    n_want = i_request_size;
                    n_rel  = i_release_offset;
                end
            end
            ffha_pkg::S_PREP: begin
                alu_a = WW'(r_want);
                alu_b = HDR_LEN;
                n_wh  = alu_sum;
                n_pos = '0;
            end
            ffha_pkg::S_WALK: begin
                alu_a     = WW'(r_pos);
                alu_b     = HDR_LEN;
                n_pay     = alu_sum;
                ram_raddr = r_pos;
                if (alu_sum > HEAP_W) begin
                    n_done       = 1'b1;
                    n_out_off    = '0;
                    n_out_cap    = '0;
                    n_out_status = ffha_pkg::STATUS_NO_FIT;
                end
            end
            ffha_pkg::S_CHK: begin
                alu_op = ffha_pkg::ALU_SUB;
                alu_a  = WW'(ram_rdata.cap);
                alu_b  = WW'(r_want);
                n_cap  = ram_rdata.cap;
                n_res  = ram_rdata.res;
            end
            ffha_pkg::S_FIT: begin
                alu_op = ffha_pkg::ALU_SUB;
                alu_a  = r_wh;
                alu_b  = WW'(r_cap);
                if (!alu_borrow) begin
                    ram_we       = 1'b1;
                    ram_wdata    = '{size: r_want, cap: r_cap, res: 1'b1};
                    n_done       = 1'b1;
                    n_out_off    = r_pay[FW-1:0];
                    n_out_cap    = r_cap;
                    n_out_status = ffha_pkg::STATUS_OK;
                end
            end
            ffha_pkg::S_SPLIT1: begin
                alu_op    = ffha_pkg::ALU_SUB;
                alu_a     = WW'(r_cap);
                alu_b     = r_wh;
                n_acc     = alu_sum;
                ram_we    = 1'b1;
                ram_wdata = '{size: r_want, cap: r_want, res: 1'b1};
            end
            ffha_pkg::S_SPLIT2: begin
                alu_a        = r_pay;
                alu_b        = WW'(r_want);
                ram_we       = (alu_sum < HEAP_W);
                ram_waddr    = alu_sum[AW-1:0];
                ram_wdata    = '{size: r_acc[FW-1:0], cap: r_acc[FW-1:0], res: 1'b0};
                n_done       = 1'b1;
                n_out_off    = r_pay[FW-1:0];
                n_out_cap    = r_want;
                n_out_status = ffha_pkg::STATUS_OK;
            end
            ffha_pkg::S_NEXT: begin
                alu_a  = r_pay;
                alu_b  = WW'(r_cap);
                n_next = alu_sum;
            end
            ffha_pkg::S_NEXT2: begin
                alu_a     = r_next;
                alu_b     = HDR_LEN;
                ram_raddr = r_next[AW-1:0];
                priority if (alu_sum > HEAP_W) begin
                    n_done       = 1'b1;
                    n_out_off    = '0;
                    n_out_cap    = '0;
                    n_out_status = ffha_pkg::STATUS_NO_FIT;
                end else if (r_res) begin
                    n_pos = r_next[AW-1:0];
                end else begin
                    n_pos = r_pos;
                end
            end
            ffha_pkg::S_MRG: begin
                alu_a = WW'(r_cap);
                alu_b = WW'(ram_rdata.cap);
                n_acc = alu_sum;
                if (ram_rdata.res) begin
                    n_pos = r_next[AW-1:0];
                end
            end
            ffha_pkg::S_MRG2: begin
                alu_a     = r_acc;
                alu_b     = HDR_LEN;
                ram_we    = 1'b1;
                ram_wdata = '{size: alu_sum[FW-1:0], cap: alu_sum[FW-1:0], res: 1'b0};
            end
            ffha_pkg::S_FREE_CHK: begin
                alu_op    = ffha_pkg::ALU_SUB;
                alu_a     = WW'(r_rel);
                alu_b     = HDR_LEN;
                n_pos     = alu_sum[AW-1:0];
                ram_raddr = alu_sum[AW-1:0];
                if (alu_borrow || alu_sum >= HEAP_W) begin
                    n_done       = 1'b1;
                    n_out_off    = r_rel;
                    n_out_cap    = '0;
                    n_out_status = ffha_pkg::STATUS_OK;
                end
            end
            ffha_pkg::S_FREE_RD: begin
                ram_we       = 1'b1;
                ram_wdata    = '{size: ram_rdata.cap, cap: ram_rdata.cap, res: 1'b0};
                n_done       = 1'b1;
                n_out_off    = r_rel;
                n_out_cap    = '0;
                n_out_status = ffha_pkg::STATUS_OK;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_pos        <= n_pos;
        r_want       <= n_want;
        r_rel        <= n_rel;
        r_wh         <= n_wh;
        r_pay        <= n_pay;
        r_cap        <= n_cap;
        r_res        <= n_res;
        r_next       <= n_next;
        r_acc        <= n_acc;
        r_out_off    <= n_out_off;
        r_out_cap    <= n_out_cap;
        r_out_status <= n_out_status;
    end

    assign busy               = (r_state != ffha_pkg::S_IDLE);
    assign o_done             = r_done;
    assign o_payload_offset   = r_out_off;
    assign o_granted_capacity = r_out_cap;
    assign o_status           = r_out_status;

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("Result strobe while the sequencer is still busy.");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted item did not start the sequencer.");

    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ffha_pkg::STATUS_NO_FIT) |->
            (o_payload_offset == '0 && o_granted_capacity == '0))
        else $error("Failed allocation reports a nonzero offset or capacity.");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("Result strobe without an item in progress.");

endmodule

// File: tb/first_fit_heap_allocator_unit_test.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit_test;

    localparam int HEAP_BYTES   = 8192;
    localparam int HEADER_BYTES = 9;
    localparam int MAX_REQUEST  = HEAP_BYTES - HEADER_BYTES;
    localparam int PHASE_ITEMS  = 300;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [ffha_pkg::FIELD_W-1:0] offset;
        logic [ffha_pkg::FIELD_W-1:0] capacity;
        logic                         status;
    } t_grant;

    typedef struct packed {
        logic                         cmd;
        logic [ffha_pkg::FIELD_W-1:0] req;
        logic [ffha_pkg::FIELD_W-1:0] rel;
        logic                         fixed;
        logic [ffha_pkg::FIELD_W-1:0] off;
        logic [ffha_pkg::FIELD_W-1:0] cap;
        logic                         st;
    } t_plan_row;

    localparam int PLAN_ROWS = 23;
    localparam t_plan_row DIRECTED_ITEMS [0:PLAN_ROWS-1] = '{
        '{ffha_pkg::CMD_ALLOC, 13'd0, 13'd0, 1'b1, 13'd9, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_FREE, 13'd0, 13'd0, 1'b1, 13'd0, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_FREE, 13'd0, 13'd8, 1'b1, 13'd8, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_ALLOC, 13'd8183, 13'd8191, 1'b1, 13'd0, 13'd0, ffha_pkg::STATUS_NO_FIT},
        '{ffha_pkg::CMD_FREE, 13'd8183, 13'd9, 1'b1, 13'd9, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_ALLOC, 13'd8183, 13'd0, 1'b1, 13'd9, 13'd8183, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_ALLOC, 13'd0, 13'd0, 1'b1, 13'd0, 13'd0, ffha_pkg::STATUS_NO_FIT},
        '{ffha_pkg::CMD_FREE, 13'd0, 13'd18, 1'b1, 13'd18, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_FREE, 13'd0, 13'd9, 1'b1, 13'd9, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_ALLOC, 13'd8173, 13'd0, 1'b0, 13'd0, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_FREE, 13'd0, 13'd8191, 1'b1, 13'd8191, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_ALLOC, 13'd1, 13'd0, 1'b0, 13'd0, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_FREE, 13'd0, 13'd9, 1'b1, 13'd9, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_FREE, 13'd0, 13'd8191, 1'b1, 13'd8191, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_ALLOC, 13'd100, 13'd0, 1'b0, 13'd0, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_ALLOC, 13'd200, 13'd0, 1'b0, 13'd0, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_ALLOC, 13'd50, 13'd0, 1'b0, 13'd0, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_FREE, 13'd0, 13'd118, 1'b1, 13'd118, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_ALLOC, 13'd91, 13'd0, 1'b0, 13'd0, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_FREE, 13'd0, 13'd118, 1'b1, 13'd118, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_ALLOC, 13'd90, 13'd0, 1'b0, 13'd0, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_ALLOC, 13'd0, 13'd0, 1'b0, 13'd0, 13'd0, ffha_pkg::STATUS_OK},
        '{ffha_pkg::CMD_FREE, 13'd0, 13'd8191, 1'b1, 13'd8191, 13'd0, ffha_pkg::STATUS_OK}
    };

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         i_command = ffha_pkg::CMD_ALLOC;
    logic [ffha_pkg::FIELD_W-1:0] i_request_size = '0;
    logic [ffha_pkg::FIELD_W-1:0] i_release_offset = '0;
    logic                         o_done;
    logic [ffha_pkg::FIELD_W-1:0] o_payload_offset;
    logic [ffha_pkg::FIELD_W-1:0] o_granted_capacity;
    logic                         o_status;

    ffha_pkg::t_header heap_headers [HEAP_BYTES];
    bit                header_written [HEAP_BYTES];
    int                reserved_offsets [$];
    t_grant            pending_grants [$];

    int cycle_count = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int alloc_count = 0;
    int free_count = 0;
    int no_fit_count = 0;

    first_fit_heap_allocator_unit #(
        .HEAP_BYTES  (HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_request_size    (i_request_size),
        .i_release_offset  (i_release_offset),
        .o_done            (o_done),
        .o_payload_offset  (o_payload_offset),
        .o_granted_capacity(o_granted_capacity),
        .o_status          (o_status)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic void write_header(int at, int size, int cap, logic res);
        if (at < HEAP_BYTES) begin
            heap_headers[at].size = size[ffha_pkg::FIELD_W-1:0];
            heap_headers[at].cap  = cap[ffha_pkg::FIELD_W-1:0];
            heap_headers[at].res  = res;
            header_written[at]    = 1'b1;
        end
    endfunction

    function automatic void clear_heap();
        for (int i = 0; i < HEAP_BYTES; i++) begin
            heap_headers[i]   = '0;
            header_written[i] = 1'b0;
        end
        write_header(0, MAX_REQUEST, MAX_REQUEST, 1'b0);
    endfunction

    function automatic t_grant first_fit_grant(int want);
        int     pos;
        int     cap;
        int     nxt;
        int     rest;
        int     merged;
        t_grant grant;
        pos = 0;
        grant.offset   = '0;
        grant.capacity = '0;
        grant.status   = ffha_pkg::STATUS_NO_FIT;
        while (pos + HEADER_BYTES <= HEAP_BYTES) begin
            cap = heap_headers[pos].cap;
            if (!heap_headers[pos].res && cap >= want) begin
                if (cap <= want + HEADER_BYTES) begin
                    write_header(pos, want, cap, 1'b1);
                    grant.capacity = cap[ffha_pkg::FIELD_W-1:0];
                end else begin
                    rest = cap - (want + HEADER_BYTES);
                    write_header(pos, want, want, 1'b1);
                    write_header(pos + HEADER_BYTES + want, rest, rest, 1'b0);
                    grant.capacity = want[ffha_pkg::FIELD_W-1:0];
                end
                nxt = pos + HEADER_BYTES;
                grant.offset = nxt[ffha_pkg::FIELD_W-1:0];
                grant.status = ffha_pkg::STATUS_OK;
                return grant;
            end
            nxt = pos + HEADER_BYTES + cap;
            if (nxt + HEADER_BYTES > HEAP_BYTES) begin
                break;
            end
            if (!heap_headers[pos].res && !heap_headers[nxt].res) begin
                merged = cap + int'(heap_headers[nxt].cap) + HEADER_BYTES;
                write_header(pos, merged, merged, 1'b0);
            end else begin
                pos = nxt;
            end
        end
        return grant;
    endfunction

    function automatic t_grant heap_response(logic cmd, int req, int rel);
        int     at;
        int     cap;
        t_grant grant;
        if (cmd == ffha_pkg::CMD_ALLOC) begin
            return first_fit_grant(req);
        end
        if (rel >= HEADER_BYTES) begin
            at = rel - HEADER_BYTES;
            cap = heap_headers[at].cap;
            write_header(at, cap, cap, 1'b0);
        end
        grant.offset   = rel[ffha_pkg::FIELD_W-1:0];
        grant.capacity = '0;
        grant.status   = ffha_pkg::STATUS_OK;
        return grant;
    endfunction

    function automatic void collect_reserved();
        int pos;
        pos = 0;
        reserved_offsets.delete();
        while (pos + HEADER_BYTES <= HEAP_BYTES) begin
            if (heap_headers[pos].res) begin
                reserved_offsets.push_back(pos + HEADER_BYTES);
            end
            pos = pos + HEADER_BYTES + int'(heap_headers[pos].cap);
        end
    endfunction

    // An offset with a written header slot (live or stale), else one below 9.
    function automatic int pick_written_offset();
        int rel;
        for (int tries = 0; tries < 20; tries++) begin
            rel = $urandom_range(HEAP_BYTES - 1, HEADER_BYTES);
            if (header_written[rel - HEADER_BYTES]) begin
                return rel;
            end
        end
        return $urandom_range(HEADER_BYTES - 1);
    endfunction

    function automatic int pick_request_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 2) begin
            return MAX_REQUEST;
        end else if (roll < 5) begin
            return 0;
        end else if (roll < 52) begin
            return $urandom_range(63);
        end else if (roll < 87) begin
            return $urandom_range(511, 64);
        end
        return $urandom_range(MAX_REQUEST, 512);
    endfunction

    task automatic issue_item(input logic cmd, input int req, input int rel, input int idle_pct,
                              input bit fixed, input t_grant fixed_grant);
        t_grant grant;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start            <= 1'b1;
        i_command        <= cmd;
        i_request_size   <= req[ffha_pkg::FIELD_W-1:0];
        i_release_offset <= rel[ffha_pkg::FIELD_W-1:0];
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        grant = heap_response(cmd, req, rel);
        pending_grants.push_back(fixed ? fixed_grant : grant);
        if (cmd == ffha_pkg::CMD_ALLOC) begin
            alloc_count++;
            if (grant.status == ffha_pkg::STATUS_NO_FIT) begin
                no_fit_count++;
            end
        end else begin
            free_count++;
        end
    endtask

    task automatic report_mismatch(input string what, input t_grant expected);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch (%s) at cycle %0d: expected offset %0d capacity %0d status %0d,",
                     what, cycle_count, expected.offset, expected.capacity, expected.status);
            $display("    got offset %0d capacity %0d status %0d",
                     o_payload_offset, o_granted_capacity, o_status);
        end
    endtask

    always @(posedge i_clk) begin
        t_grant expected;
        if (i_rst_n && o_done) begin
            if (pending_grants.size() == 0) begin
                expected = '0;
                report_mismatch("unexpected result", expected);
            end else begin
                expected = pending_grants.pop_front();
                results_checked++;
                if (o_payload_offset !== expected.offset ||
                    o_granted_capacity !== expected.capacity ||
                    o_status !== expected.status) begin
                    report_mismatch("wrong field", expected);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_grants.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int        phase_idle [3];
        int        idle_pct;
        int        req;
        int        rel;
        int        roll;
        bit        do_free;
        t_plan_row row;
        t_grant    fixed_grant;
        phase_idle = '{34, 73, 0};
        clear_heap();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            row = DIRECTED_ITEMS[i];
            fixed_grant.offset   = row.off;
            fixed_grant.capacity = row.cap;
            fixed_grant.status   = row.st;
            issue_item(row.cmd, int'(row.req), int'(row.rel), 34, row.fixed, fixed_grant);
        end

        fixed_grant = '0;
        for (int phase = 0; phase < 3; phase++) begin
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                idle_pct = (k % 50 < 10) ? 0 : phase_idle[phase];
                collect_reserved();
                if (reserved_offsets.size() > 40) begin
                    do_free = ($urandom_range(99) < 70);
                end else begin
                    do_free = ($urandom_range(99) < 42);
                end
                if (do_free) begin
                    roll = $urandom_range(99);
                    req = $urandom_range(MAX_REQUEST);
                    if (roll < 6) begin
                        rel = $urandom_range(HEADER_BYTES - 1);
                    end else if (roll < 16 || reserved_offsets.size() == 0) begin
                        rel = pick_written_offset();
                    end else begin
                        rel = reserved_offsets[$urandom_range(reserved_offsets.size() - 1)];
                    end
                    issue_item(ffha_pkg::CMD_FREE, req, rel, idle_pct, 1'b0, fixed_grant);
                end else begin
                    req = pick_request_size();
                    rel = $urandom_range(HEAP_BYTES - 1);
                    issue_item(ffha_pkg::CMD_ALLOC, req, rel, idle_pct, 1'b0, fixed_grant);
                end
            end
        end
        start <= 1'b0;

        while (pending_grants.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d directed and %0d random items, sender idle 34, 73 and 0 percent.",
                 PLAN_ROWS, 3 * PHASE_ITEMS);
        $display("%0d allocates (%0d no fit), %0d frees, %0d checked, %0d mismatches.",
                 alloc_count, no_fit_count, free_count, results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_grants.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
